### rtl/bpc_pkg.sv
// ============================================================================
// bpc_pkg
// Shared constants for the barometric pressure and temperature compensation
// pipeline: register indexes, port widths, divider sizes and compensation constants.
// ============================================================================
package bpc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_AC123 = 3'd0;
  localparam logic [2:0] REG_AC456 = 3'd1;
  localparam logic [2:0] REG_B1B2  = 3'd2;
  localparam logic [2:0] REG_MCMD  = 3'd3;
  localparam logic [2:0] REG_OSS   = 3'd4;

  // Port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // Temperature divider: |MC| * 2048 over |X1 + MD|
  localparam int TDIV_NUM_W  = 27;
  localparam int TDIV_DEN_W  = 18;
  localparam int TDIV_SIDE_W = 40;

  // Pressure divider: B7 (or 2 * B7) over B4
  localparam int PDIV_NUM_W  = 32;
  localparam int PDIV_DEN_W  = 33;
  localparam int PDIV_SIDE_W = 18;

  // Compensation constants
  localparam int B6_OFFSET   = 4000;
  localparam int P_SQ_COEF   = 3038;
  localparam int P_LIN_COEF  = 7357;
  localparam int P_OFFSET    = 3791;
  localparam int PRESS_SCALE = 50000;
  localparam int B4_BIAS     = 32768;
  localparam int PRESS_MAX   = 262143;

endpackage

### rtl/bpc_div.sv
// ============================================================================
// bpc_div
// Fully pipelined unsigned restoring divider. One quotient bit is settled
// per stage, so a new division enters every enabled cycle. A side vector
// travels alongside each division.
// ============================================================================
module bpc_div import bpc_pkg::*; #(
  parameter int NumW  = TDIV_NUM_W,
  parameter int DenW  = TDIV_DEN_W,
  parameter int SideW = TDIV_SIDE_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NumW-1:0]  in_num,
  input  logic [DenW-1:0]  in_den,
  input  logic [SideW-1:0] in_side,
  output logic             out_valid,
  output logic [NumW-1:0]  out_quo,
  output logic [SideW-1:0] out_side
);

  // Per stage: dividend bits still to shift out, with quotient bits shifted in
  logic [NumW-1:0]  nq_r   [NumW];
  logic [SideW-1:0] side_r [NumW];
  logic             vld_r  [NumW];
  logic [DenW-1:0]  rem_r  [NumW-1];
  logic [DenW-1:0]  den_r  [NumW-1];

  for (genvar g = 0; g < NumW; g++) begin : g_stage
    logic [NumW-1:0]  src_nq;
    logic [SideW-1:0] src_side;
    logic             src_vld;
    logic [DenW-1:0]  src_rem;
    logic [DenW-1:0]  src_den;
    logic [DenW:0]    trial;
    logic             ge;

    if (g == 0) begin : g_first
      assign src_nq   = in_num;
      assign src_side = in_side;
      assign src_vld  = in_valid;
      assign src_rem  = '0;
      assign src_den  = in_den;
    end else begin : g_next
      assign src_nq   = nq_r[g-1];
      assign src_side = side_r[g-1];
      assign src_vld  = vld_r[g-1];
      assign src_rem  = rem_r[g-1];
      assign src_den  = den_r[g-1];
    end

    // Bring down the next dividend bit and try one subtraction.
    assign trial = {src_rem, src_nq[NumW-1]};
    assign ge    = (trial >= {1'b0, src_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[g]   <= {src_nq[NumW-2:0], ge};
        side_r[g] <= src_side;
      end
    end

    if (g < NumW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= ge ? DenW'(trial - {1'b0, src_den}) : trial[DenW-1:0];
          den_r[g] <= src_den;
        end
      end
    end
  end

  assign out_valid = vld_r[NumW-1];
  assign out_quo   = nq_r[NumW-1];
  assign out_side  = side_r[NumW-1];

endmodule

### rtl/baro_pressure_temp_compensation_unit.sv
// ============================================================================
// baro_pressure_temp_compensation_unit
// Integer compensation of a barometric sensor: raw temperature and pressure
// words in, temperature in 0.1 degC and pressure in Pa out.
// ============================================================================
//
// Channel   Dir  Handshake          Payload
// in_       in   tvalid / tready    tdata: raw_temp, raw_press
// out_      out  tvalid / tready    tdata: temp_decidegc, pressure_pa; tuser: div_error
// cfg_      in   wr_en              index, wdata (calibration and oversampling)
//
// One word is accepted per cycle while the output is not stalled; each word
// passes through the two bit-per-stage dividers (27 and 32 stages) plus 13
// arithmetic stages. Reset clears all valid bits and the calibration
// registers. A stalled output freezes the whole pipeline in place, and
// in_tready falls in the same cycle.
//
module baro_pressure_temp_compensation_unit import bpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] raw_temp, [34:16] raw_press
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] temp_decidegc, [33:16] pressure_pa
  output logic                  out_tuser,  // [0] div_error
  // Configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [47:0] ac123_r;
  logic [47:0] ac456_r;
  logic [31:0] b1b2_r;
  logic [31:0] mcmd_r;
  logic [1:0]  oss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac123_r <= '0;
      ac456_r <= '0;
      b1b2_r  <= '0;
      mcmd_r  <= '0;
      oss_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_AC123: ac123_r <= cfg_wdata[47:0];
        REG_AC456: ac456_r <= cfg_wdata[47:0];
        REG_B1B2:  b1b2_r  <= cfg_wdata[31:0];
        REG_MCMD:  mcmd_r  <= cfg_wdata[31:0];
        REG_OSS:   oss_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Coefficient fields
  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [15:0] ac4, ac5, ac6;

  assign ac1 = $signed(ac123_r[47:32]);
  assign ac2 = $signed(ac123_r[31:16]);
  assign ac3 = $signed(ac123_r[15:0]);
  assign ac4 = ac456_r[47:32];
  assign ac5 = ac456_r[31:16];
  assign ac6 = ac456_r[15:0];
  assign b1  = $signed(b1b2_r[31:16]);
  assign b2  = $signed(b1b2_r[15:0]);
  assign mc  = $signed(mcmd_r[31:16]);
  assign md  = $signed(mcmd_r[15:0]);

  // Pipeline advances whenever the output register is free or being taken.
  logic out_valid_r;
  logic en;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Stage 1: UT - AC6
  logic               v1_r;
  logic signed [16:0] s1_d_r;
  logic        [18:0] s1_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r  <= $signed({1'b0, in_tdata[15:0]}) - $signed({1'b0, ac6});
      s1_up_r <= in_tdata[34:16];
    end
  end

  // Stage 2: (UT - AC6) * AC5
  logic               v2_r;
  logic signed [33:0] s2_m_r;
  logic        [18:0] s2_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_m_r  <= s1_d_r * $signed({1'b0, ac5});
      s2_up_r <= s1_up_r;
    end
  end

  // Stage 3: X1 and the temperature divisor X1 + MD
  logic               v3_r;
  logic signed [18:0] s3_x1_r;
  logic signed [19:0] s3_den_r;
  logic        [18:0] s3_up_r;
  logic signed [18:0] x1_nxt;

  assign x1_nxt = 19'(s2_m_r >>> 15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_x1_r  <= x1_nxt;
      s3_den_r <= 20'(x1_nxt) + 20'(md);
      s3_up_r  <= s2_up_r;
    end
  end

  // Temperature division on magnitudes; the sign is restored afterward.
  logic [19:0]             den_mag;
  logic [15:0]             mc_mag;
  logic [TDIV_NUM_W-1:0]   tdiv_num;
  logic [TDIV_SIDE_W-1:0]  tdiv_side_in;
  logic                    tdiv_valid;
  logic [TDIV_NUM_W-1:0]   tdiv_quo;
  logic [TDIV_SIDE_W-1:0]  tdiv_side;

  assign den_mag      = s3_den_r[19] ? 20'(-s3_den_r) : 20'(s3_den_r);
  assign mc_mag       = mc[15] ? 16'(-mc) : 16'(mc);
  assign tdiv_num     = {mc_mag, 11'b0};
  assign tdiv_side_in = {s3_up_r, s3_x1_r, mc[15] ^ s3_den_r[19], (s3_den_r == 20'sd0)};

  bpc_div #(
    .NumW  (TDIV_NUM_W),
    .DenW  (TDIV_DEN_W),
    .SideW (TDIV_SIDE_W)
  ) u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_num    (tdiv_num),
    .in_den    (den_mag[TDIV_DEN_W-1:0]),
    .in_side   (tdiv_side_in),
    .out_valid (tdiv_valid),
    .out_quo   (tdiv_quo),
    .out_side  (tdiv_side)
  );

  // Stage 4: B5 = X1 + X2
  logic               v4_r;
  logic signed [29:0] s4_b5_r;
  logic               s4_err_r;
  logic        [18:0] s4_up_r;
  logic signed [27:0] q_s;
  logic signed [27:0] x2_t;

  assign q_s  = $signed({1'b0, tdiv_quo});
  assign x2_t = tdiv_side[1] ? -q_s : q_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= tdiv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_b5_r  <= 30'($signed(tdiv_side[20:2])) + 30'(x2_t);
      s4_err_r <= tdiv_side[0];
      s4_up_r  <= tdiv_side[39:21];
    end
  end

  // Stage 5: temperature result and B6
  logic               v5_r;
  logic signed [15:0] s5_t_r;
  logic signed [29:0] s5_b6_r;
  logic               s5_err_r;
  logic        [18:0] s5_up_r;
  logic signed [29:0] t_full;
  logic signed [15:0] t_sat;

  assign t_full = (s4_b5_r + 30'sd8) >>> 4;

  always_comb begin
    if (t_full > 30'sd32767) begin
      t_sat = 16'sh7FFF;
    end else if (t_full < -30'sd32768) begin
      t_sat = -16'sh8000;
    end else begin
      t_sat = 16'(t_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_t_r   <= t_sat;
      s5_b6_r  <= s4_b5_r - 30'(B6_OFFSET);
      s5_err_r <= s4_err_r;
      s5_up_r  <= s4_up_r;
    end
  end

  // Stage 6: B6 squared, AC2 * B6, AC3 * B6
  logic               v6_r;
  logic signed [59:0] s6_sq_r;
  logic signed [45:0] s6_a2_r;
  logic signed [45:0] s6_a3_r;
  logic signed [15:0] s6_t_r;
  logic               s6_err_r;
  logic        [18:0] s6_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_sq_r  <= s5_b6_r * s5_b6_r;
      s6_a2_r  <= ac2 * s5_b6_r;
      s6_a3_r  <= ac3 * s5_b6_r;
      s6_t_r   <= s5_t_r;
      s6_err_r <= s5_err_r;
      s6_up_r  <= s5_up_r;
    end
  end

  // Stage 7: B2 * sq and B1 * sq
  logic               v7_r;
  logic signed [63:0] s7_p2_r;
  logic signed [63:0] s7_p1_r;
  logic signed [34:0] s7_a2_r;
  logic signed [32:0] s7_a3_r;
  logic signed [15:0] s7_t_r;
  logic               s7_err_r;
  logic        [18:0] s7_up_r;
  logic signed [47:0] sq;

  assign sq = 48'(s6_sq_r >>> 12);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_p2_r  <= b2 * sq;
      s7_p1_r  <= b1 * sq;
      s7_a2_r  <= 35'(s6_a2_r >>> 11);
      s7_a3_r  <= 33'(s6_a3_r >>> 13);
      s7_t_r   <= s6_t_r;
      s7_err_r <= s6_err_r;
      s7_up_r  <= s6_up_r;
    end
  end

  // Stage 8: X3 for B3 and X3 for B4
  logic               v8_r;
  logic signed [53:0] s8_x3_r;
  logic signed [49:0] s8_x3b_r;
  logic signed [15:0] s8_t_r;
  logic               s8_err_r;
  logic        [18:0] s8_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_x3_r  <= 54'(s7_p2_r >>> 11) + 54'(s7_a2_r);
      s8_x3b_r <= (50'(s7_a3_r) + 50'(s7_p1_r >>> 16) + 50'sd2) >>> 2;
      s8_t_r   <= s7_t_r;
      s8_err_r <= s7_err_r;
      s8_up_r  <= s7_up_r;
    end
  end

  // Stage 9: B3 (quotient toward zero) and the B4 product
  logic               v9_r;
  logic        [31:0] s9_b3_r;
  logic        [47:0] s9_b4p_r;
  logic signed [15:0] s9_t_r;
  logic               s9_err_r;
  logic        [18:0] s9_up_r;
  logic signed [63:0] b3_num;
  logic signed [63:0] b3_full;
  logic signed [49:0] x3b_bias;

  assign b3_num   = (((64'(ac1) <<< 2) + 64'(s8_x3_r)) <<< oss_r) + 64'sd2;
  assign b3_full  = b3_num[63] ? ((b3_num + 64'sd3) >>> 2) : (b3_num >>> 2);
  assign x3b_bias = s8_x3b_r + 50'(B4_BIAS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_b3_r  <= b3_full[31:0];
      s9_b4p_r <= 48'(ac4) * 48'(x3b_bias[31:0]);
      s9_t_r   <= s8_t_r;
      s9_err_r <= s8_err_r;
      s9_up_r  <= s8_up_r;
    end
  end

  // Stage 10: B4 and B7 (B7 wraps at 32 bits)
  logic               v10_r;
  logic        [32:0] s10_b4_r;
  logic        [31:0] s10_b7_r;
  logic signed [15:0] s10_t_r;
  logic               s10_err_r;
  logic        [31:0] b7_diff;
  logic        [15:0] b7_scale;

  assign b7_diff  = 32'(s9_up_r) - s9_b3_r;
  assign b7_scale = 16'(PRESS_SCALE >> oss_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (en) begin
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_b4_r  <= s9_b4p_r[47:15];
      s10_b7_r  <= 32'(b7_diff * 32'(b7_scale));
      s10_t_r   <= s9_t_r;
      s10_err_r <= s9_err_r || (s9_b4p_r[47:15] == 33'd0);
    end
  end

  // Pressure division: 2 * B7 / B4, or B7 / B4 doubled when B7 is large
  logic [PDIV_NUM_W-1:0]  pdiv_num;
  logic [PDIV_SIDE_W-1:0] pdiv_side_in;
  logic                   pdiv_valid;
  logic [PDIV_NUM_W-1:0]  pdiv_quo;
  logic [PDIV_SIDE_W-1:0] pdiv_side;

  assign pdiv_num     = s10_b7_r[31] ? s10_b7_r : {s10_b7_r[30:0], 1'b0};
  assign pdiv_side_in = {s10_b7_r[31], s10_err_r, s10_t_r};

  bpc_div #(
    .NumW  (PDIV_NUM_W),
    .DenW  (PDIV_DEN_W),
    .SideW (PDIV_SIDE_W)
  ) u_pdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v10_r),
    .in_num    (pdiv_num),
    .in_den    (s10_b4_r),
    .in_side   (pdiv_side_in),
    .out_valid (pdiv_valid),
    .out_quo   (pdiv_quo),
    .out_side  (pdiv_side)
  );

  // Stage 12: p, (p >> 8) squared, -7357 * p
  logic               v12_r;
  logic        [32:0] s12_p_r;
  logic        [49:0] s12_sq_r;
  logic signed [48:0] s12_y2_r;
  logic signed [15:0] s12_t_r;
  logic               s12_err_r;
  logic        [32:0] p_q;

  assign p_q = pdiv_side[17] ? {pdiv_quo, 1'b0} : {1'b0, pdiv_quo};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v12_r <= 1'b0;
    end else if (en) begin
      v12_r <= pdiv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s12_p_r   <= p_q;
      s12_sq_r  <= 50'(p_q[32:8]) * 50'(p_q[32:8]);
      s12_y2_r  <= -49'(P_LIN_COEF) * $signed({16'b0, p_q});
      s12_t_r   <= $signed(pdiv_side[15:0]);
      s12_err_r <= pdiv_side[16];
    end
  end

  // Stage 13: 3038 * sq term
  logic               v13_r;
  logic        [32:0] s13_p_r;
  logic        [45:0] s13_x1_r;
  logic signed [32:0] s13_x2_r;
  logic signed [15:0] s13_t_r;
  logic               s13_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v13_r <= 1'b0;
    end else if (en) begin
      v13_r <= v12_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s13_p_r   <= s12_p_r;
      s13_x1_r  <= 46'((62'(s12_sq_r) * 62'(P_SQ_COEF)) >> 16);
      s13_x2_r  <= 33'(s12_y2_r >>> 16);
      s13_t_r   <= s12_t_r;
      s13_err_r <= s12_err_r;
    end
  end

  // Stage 14: final pressure, saturation and the output register
  logic signed [47:0] p_corr;
  logic signed [48:0] p_final;
  logic        [17:0] p_sat;
  logic        [15:0] out_temp_r;
  logic        [17:0] out_press_r;
  logic               out_err_r;

  assign p_corr  = ($signed({2'b0, s13_x1_r}) + 48'(s13_x2_r) + 48'(P_OFFSET)) >>> 4;
  assign p_final = $signed({16'b0, s13_p_r}) + 49'(p_corr);

  always_comb begin
    if (p_final < 49'sd0) begin
      p_sat = '0;
    end else if (p_final > 49'(PRESS_MAX)) begin
      p_sat = 18'(PRESS_MAX);
    end else begin
      p_sat = p_final[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v13_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_temp_r  <= s13_err_r ? 16'd0 : s13_t_r;
      out_press_r <= s13_err_r ? 18'd0 : p_sat;
      out_err_r   <= s13_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_press_r, out_temp_r};
  assign out_tuser  = out_err_r;

`ifndef SYNTHESIS
  // A flagged divide error always carries zero results.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[33:0] == 34'd0)
    else $error("divide error word with nonzero results");

  // Reset leaves no word in the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A word held at the output while stalled stays unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(out_temp_r) && $stable(out_press_r) && $stable(v13_r))
    else $error("pipeline moved during a stall");
`endif

endmodule

### tb/tb_baro_pressure_temp_compensation_unit.sv
// ============================================================================
// tb_baro_pressure_temp_compensation_unit
// Self-checking testbench for the barometric compensation pipeline. Raw
// temperature and pressure words are streamed in under several calibration
// sets. Each result word is checked against an in-bench integer predictor or
// against hand-computed values. The input and output sides idle at random,
// and there is one long output hold-off.
// ============================================================================
module tb_baro_pressure_temp_compensation_unit import bpc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Index past the register list; writes to it must be ignored.
  localparam logic [2:0] REG_NONE = 3'd5;
  localparam int         WATCHDOG = 3000;
  localparam int         DRAIN    = 90;

  typedef struct packed {
    logic [47:0] ac123;
    logic [47:0] ac456;
    logic [31:0] b1b2;
    logic [31:0] mcmd;
    logic [1:0]  oss;
  } calib_t;

  typedef struct packed {
    logic [15:0] temp;
    logic [17:0] press;
    logic        err;
  } reading_t;

  typedef struct packed {
    int          cal;     // calibration set used for this row
    logic [15:0] ut;
    logic [18:0] up;
    logic        typed;   // expected value given in the row
    reading_t    want;
  } row_t;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  calib_t   cal_now = '0;
  reading_t pending_readings[$];
  int       mismatches = 0;
  bit       failed = 0;
  bit       quiet = 0;
  bit       hold_req = 0;

  baro_pressure_temp_compensation_unit u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Integer compensation of one raw pair under the current calibration.
  function automatic reading_t compensate(logic [15:0] ut_raw, logic [18:0] up_raw);
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint ut, up, x1, x2, x3, b3, b5, b6, sq, t, p, den;
    longint unsigned b4, b7w;
    logic [31:0] bias, diff, b7;
    int os;
    reading_t r;
    r = '{temp: '0, press: '0, err: 1'b1};
    ac1 = longint'($signed(cal_now.ac123[47:32]));
    ac2 = longint'($signed(cal_now.ac123[31:16]));
    ac3 = longint'($signed(cal_now.ac123[15:0]));
    ac4 = longint'(cal_now.ac456[47:32]);
    ac5 = longint'(cal_now.ac456[31:16]);
    ac6 = longint'(cal_now.ac456[15:0]);
    b1  = longint'($signed(cal_now.b1b2[31:16]));
    b2  = longint'($signed(cal_now.b1b2[15:0]));
    mc  = longint'($signed(cal_now.mcmd[31:16]));
    md  = longint'($signed(cal_now.mcmd[15:0]));
    os  = int'(cal_now.oss);
    ut  = longint'(ut_raw);
    up  = longint'(up_raw);

    // Temperature path
    x1  = ((ut - ac6) * ac5) >>> 15;
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t  = (b5 + 8) >>> 4;

    // Pressure path
    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << os) + 2) / 4;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    bias = 32'(x3 + 32768);
    b4 = (longint'(unsigned'(ac4)) * {32'b0, bias}) >> 15;
    if (b4 == 0) return r;
    diff = 32'(up - b3);
    b7   = diff * (32'd50000 >> os);
    b7w  = {32'b0, b7};
    if (b7 < 32'h8000_0000) p = longint'((b7w * 2) / b4);
    else                    p = longint'((b7w / b4) * 2);
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (-7357 * p) >>> 16;
    p  = p + ((x1 + x2 + 3791) >>> 4);

    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (p > PRESS_MAX) p = PRESS_MAX;
    if (p < 0) p = 0;
    r.temp  = t[15:0];
    r.press = p[17:0];
    r.err   = 1'b0;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [47:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
  endtask

  // Load a calibration set; only called while the pipeline is empty.
  task automatic load_calib(calib_t c);
    write_reg(REG_AC123, c.ac123);
    write_reg(REG_AC456, c.ac456);
    write_reg(REG_B1B2, {16'($urandom), c.b1b2});
    write_reg(REG_MCMD, {16'($urandom), c.mcmd});
    write_reg(REG_OSS, {$urandom, 14'($urandom), c.oss});
    write_reg(REG_NONE, {$urandom, 16'($urandom)});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cal_now = c;
  endtask

  task automatic drain();
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Offer one word, wait for it to be taken, and record the expected reading.
  task automatic send_word(logic [15:0] ut, logic [18:0] up, bit typed, reading_t want);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, up, ut};
    do @(posedge clk); while (!in_tready);
    pending_readings.push_back(typed ? want : compensate(ut, up));
    if (!quiet && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic calib_t random_calib();
    calib_t c;
    if ($urandom_range(9) < 7) begin
      // Coefficients scattered around a typical factory calibration.
      c.ac123 = {16'(408 + $signed($urandom_range(400)) - 200),
                 16'(-72 + $signed($urandom_range(200)) - 100),
                 16'(-14383 + $signed($urandom_range(2000)) - 1000)};
      c.ac456 = {16'(32741 - $urandom_range(2000)), 16'(32757 - $urandom_range(2000)),
                 16'(23153 + $urandom_range(2000) - 1000)};
      c.b1b2  = {16'(6190 + $urandom_range(400) - 200), 16'($urandom_range(8))};
      c.mcmd  = {16'(-8711 + $signed($urandom_range(400)) - 200),
                 16'(2868 + $urandom_range(400) - 200)};
    end else begin
      c.ac123 = {$urandom, 16'($urandom)};
      c.ac456 = {$urandom, 16'($urandom)};
      c.b1b2  = $urandom;
      c.mcmd  = $urandom;
    end
    c.oss = 2'($urandom_range(3));
    return c;
  endfunction

  // Calibration sets for the directed rows.
  calib_t dir_cal[5];
  row_t   dir_rows[$];

  initial begin
    calib_t ds;
    ds = '{ac123: {16'sd408, -16'sd72, -16'sd14383},
           ac456: {16'd32741, 16'd32757, 16'd23153},
           b1b2: {16'sd6190, 16'sd4}, mcmd: {-16'sd8711, 16'sd2868}, oss: 2'd0};
    dir_cal[0] = '0;
    dir_cal[1] = ds;
    dir_cal[2] = ds;
    dir_cal[2].oss = 2'd3;
    dir_cal[3] = ds;
    dir_cal[3].ac456[47:32] = 16'd0;          // AC4 of zero forces B4 to zero
    dir_cal[4] = '1;
    // Zero coefficients: X1 + MD is zero, so every word reports a divide error.
    dir_rows.push_back('{0, 16'd0, 19'd0, 1'b1, '{16'd0, 18'd0, 1'b1}});
    dir_rows.push_back('{0, 16'hFFFF, 19'h7FFFF, 1'b1, '{16'd0, 18'd0, 1'b1}});
    // Typical calibration: 15.0 degC and 69964 Pa.
    dir_rows.push_back('{1, 16'd27898, 19'd23843, 1'b1, '{16'd150, 18'd69964, 1'b0}});
    dir_rows.push_back('{1, 16'd0, 19'd0, 1'b0, '0});
    dir_rows.push_back('{1, 16'hFFFF, 19'h7FFFF, 1'b0, '0});
    dir_rows.push_back('{1, 16'hFFFF, 19'd0, 1'b0, '0});
    dir_rows.push_back('{1, 16'd0, 19'h7FFFF, 1'b0, '0});
    dir_rows.push_back('{2, 16'd27898, 19'd190744, 1'b0, '0});
    dir_rows.push_back('{2, 16'd0, 19'h7FFFF, 1'b0, '0});
    dir_rows.push_back('{2, 16'hFFFF, 19'd0, 1'b0, '0});
    // Zero pressure divisor.
    dir_rows.push_back('{3, 16'd27898, 19'd23843, 1'b1, '{16'd0, 18'd0, 1'b1}});
    // All-ones registers: extreme signed and unsigned coefficients.
    dir_rows.push_back('{4, 16'hFFFF, 19'h7FFFF, 1'b0, '0});
    dir_rows.push_back('{4, 16'd0, 19'd0, 1'b0, '0});
    dir_rows.push_back('{4, 16'h8000, 19'h40000, 1'b0, '0});
  end

  // Stimulus
  initial begin
    int cal_sel;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cal_sel = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cal != cal_sel) begin
        in_tvalid <= 1'b0;
        drain();
        cal_sel = dir_rows[i].cal;
        load_calib(dir_cal[cal_sel]);
      end
      send_word(dir_rows[i].ut, dir_rows[i].up, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each under a fresh calibration; the last one runs without gaps.
    for (int ph = 0; ph < 9; ph++) begin
      in_tvalid <= 1'b0;
      drain();
      load_calib(random_calib());
      quiet = (ph == 8);
      if (ph == 2) hold_req = 1;
      for (int k = 0; k < 100; k++)
        send_word(16'($urandom), 19'($urandom), 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    drain();
    if (failed || pending_readings.size() != 0)
      $display("tb_baro_pressure_temp_compensation_unit: FAIL");
    else
      $display("tb_baro_pressure_temp_compensation_unit: PASS");
    $finish;
  end

  // Result side: check each word, then choose the next ready level.
  initial begin
    int hold_cnt;
    int stall_cnt;
    reading_t want;
    hold_cnt = 0;
    stall_cnt = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_readings.size() == 0) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
        end else begin
          want = pending_readings.pop_front();
          if (out_tdata[15:0] !== want.temp || out_tdata[33:16] !== want.press ||
              out_tuser !== want.err) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected t=%0d p=%0d e=%0d, got t=%0d p=%0d e=%0d",
                       $signed(want.temp), want.press, want.err,
                       $signed(out_tdata[15:0]), out_tdata[33:16], out_tuser);
          end
        end
      end
      if (rst_n && hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        hold_cnt = 250;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end else if (rst_n && !quiet && $urandom_range(3) == 0) begin
        out_tready <= 1'b0;
        stall_cnt = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb_baro_pressure_temp_compensation_unit: FAIL");
        $finish;
      end
    end
  end

endmodule

### filelist.f
rtl/bpc_pkg.sv
rtl/bpc_div.sv
rtl/baro_pressure_temp_compensation_unit.sv
tb/tb_baro_pressure_temp_compensation_unit.sv
